### rtl/core/hvd_pkg.sv
// Shared constants, types and helper functions for the haversine distance pipeline.
package hvd_pkg;
	localparam int CordicSteps = 30;
	localparam int SqrtSteps = 32;
	localparam logic signed [33:0] CordicGain = 34'sd652032874;
	localparam logic [31:0] PhFullK = 32'd3054198966;
	localparam logic [31:0] PhHalfK = 32'd1527099483;
	localparam logic [29:0] DistK = 30'd327927182;
	localparam logic signed [33:0] Q30One = 34'sd1073741824;

	// Arctangent of 2^-i in turns, 2^32 per turn.
	function automatic logic [29:0] atan_turn(input logic [4:0] i);
		logic [29:0] r;
		begin
			unique case (i)
				5'd0: r = 30'h20000000;
				5'd1: r = 30'h12E4051E;
				5'd2: r = 30'h09FB385B;
				5'd3: r = 30'h051111D4;
				5'd4: r = 30'h028B0D43;
				5'd5: r = 30'h0145D7E1;
				5'd6: r = 30'h00A2F61E;
				5'd7: r = 30'h00517C55;
				5'd8: r = 30'h0028BE53;
				5'd9: r = 30'h00145F2F;
				5'd10: r = 30'h000A2F98;
				5'd11: r = 30'h000517CC;
				5'd12: r = 30'h00028BE6;
				5'd13: r = 30'h000145F3;
				5'd14: r = 30'h0000A2FA;
				5'd15: r = 30'h0000517D;
				5'd16: r = 30'h000028BE;
				5'd17: r = 30'h0000145F;
				5'd18: r = 30'h00000A30;
				5'd19: r = 30'h00000518;
				5'd20: r = 30'h0000028C;
				5'd21: r = 30'h00000146;
				5'd22: r = 30'h000000A3;
				5'd23: r = 30'h00000051;
				5'd24: r = 30'h00000029;
				5'd25: r = 30'h00000014;
				5'd26: r = 30'h0000000A;
				5'd27: r = 30'h00000005;
				5'd28: r = 30'h00000003;
				5'd29: r = 30'h00000001;
				default: r = 30'h0;
			endcase
			return r;
		end
	endfunction

	// Per-cell control carried alongside the data.
	typedef struct packed {
		logic valid;
	} hvd_ctl_t;
endpackage

### rtl/core/haversine_distance.sv
// Top level of the pipelined haversine great-circle distance block.
//
// Channel | Direction | Handshake        | Word
// in      | input     | valid / ready    | lat_a, lon_a, lat_b, lon_b
// out     | output    | out_valid / out_ready | distance
//
// One word enters per cycle whenever the pipeline moves. A word passes through
// the phase stages, 30 rotation cells, the product stages, 32 root cells,
// 30 vectoring cells and the scaling stages, in that order.
// The whole pipeline advances together; it stalls only when the output register
// holds a word that is not taken, and it still accepts while that slot drains.
// Reset clears only the valid bits of every cell; data registers are not reset.
module haversine_distance (
	input  logic clk,
	input  logic arst_n,
	input  logic valid,
	output logic ready,
	input  logic signed [23:0] lat_a,
	input  logic signed [24:0] lon_a,
	input  logic signed [23:0] lat_b,
	input  logic signed [24:0] lon_b,
	output logic out_valid,
	input  logic out_ready,
	output logic [22:0] distance
);
	import hvd_pkg::*;

	// The pipeline moves whenever the output slot is empty or being drained.
	logic en;
	assign en = !out_valid || out_ready;
	assign ready = en;

	// Stage 1: angle differences, sign extended.
	logic v_s1;
	logic signed [24:0] la_s1, lb_s1, dlat_s1;
	logic signed [25:0] dlon_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			la_s1 <= 25'(lat_a);
			lb_s1 <= 25'(lat_b);
			dlat_s1 <= 25'(lat_b) - 25'(lat_a);
			dlon_s1 <= 26'(lon_b) - 26'(lon_a);
		end
	end

	// Stage 2: phases in turns (low 32 bits of x*k >> 24), then quadrant folding.
	logic v_s2;
	logic [3:0][31:0] ph;
	logic [3:0][31:0] pr;
	logic [3:0][63:0] prod;
	logic signed [3:0][33:0] x0, y0;
	logic signed [3:0][31:0] z0_s2;
	logic [3:0][1:0] q0_s2;

	always_comb begin
		prod[0] = 64'(65'(signed'(la_s1)) * 65'({1'b0, PhFullK}));
		prod[1] = 64'(65'(signed'(lb_s1)) * 65'({1'b0, PhFullK}));
		prod[2] = 64'(65'(signed'(dlat_s1)) * 65'({1'b0, PhHalfK}));
		prod[3] = 64'(65'(signed'(dlon_s1)) * 65'({1'b0, PhHalfK}));
		for (int l = 0; l < 4; l++) begin
			ph[l] = prod[l][55:24];
			pr[l] = ph[l] + 32'h20000000;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int l = 0; l < 4; l++) begin
				q0_s2[l] <= pr[l][31:30];
				z0_s2[l] <= signed'({2'b00, pr[l][29:0]}) - 32'sh20000000;
			end
		end
	end

	always_comb begin
		for (int l = 0; l < 4; l++) begin
			x0[l] = CordicGain;
			y0[l] = '0;
		end
	end

	// Rotation chain: 30 cells.
	logic rv [CordicSteps+1];
	logic signed [3:0][33:0] rx [CordicSteps+1];
	logic signed [3:0][33:0] ry [CordicSteps+1];
	logic signed [3:0][31:0] rz [CordicSteps+1];
	logic [3:0][1:0] rq [CordicSteps+1];

	assign rv[0] = v_s2;
	assign rx[0] = x0;
	assign ry[0] = y0;
	assign rz[0] = z0_s2;
	assign rq[0] = q0_s2;

	for (genvar g = 0; g < CordicSteps; g++) begin : g_rot
		hvd_rot_cell u_cell (
			.clk(clk), .arst_n(arst_n), .en(en), .step(5'(g)),
			.in_valid(rv[g]), .x_in(rx[g]), .y_in(ry[g]), .z_in(rz[g]), .q_in(rq[g]),
			.out_valid(rv[g+1]), .x_out(rx[g+1]), .y_out(ry[g+1]), .z_out(rz[g+1]),
			.q_out(rq[g+1])
		);
	end

	// Quadrant mapping to cos and sin.
	logic signed [3:0][33:0] cs, sn;
	logic signed [3:0][33:0] fx, fy;

	always_comb begin
		for (int l = 0; l < 4; l++) begin
			fx[l] = rx[CordicSteps][l];
			fy[l] = ry[CordicSteps][l];
			unique case (rq[CordicSteps][l])
				2'd0: begin cs[l] = fx[l]; sn[l] = fy[l]; end
				2'd1: begin cs[l] = -fy[l]; sn[l] = fx[l]; end
				2'd2: begin cs[l] = -fx[l]; sn[l] = -fy[l]; end
				default: begin cs[l] = fy[l]; sn[l] = -fx[l]; end
			endcase
		end
	end

	// Product stage A: ca*cb, u*u, v*v.
	logic v_p1, v_p2, v_p3;
	logic signed [33:0] cc_p1, uu_p1, vv_p1;
	logic signed [67:0] m_cc, m_uu, m_vv, m_h;
	logic signed [33:0] t_p2, uu_p2;
	logic [33:0] h_p3;
	logic signed [34:0] hs;

	// Lane selects of the packed arrays are unsigned, so each is taken as signed here.
	assign m_cc = 68'(signed'(cs[0])) * 68'(signed'(cs[1]));
	assign m_uu = 68'(signed'(sn[2])) * 68'(signed'(sn[2]));
	assign m_vv = 68'(signed'(sn[3])) * 68'(signed'(sn[3]));
	assign m_h = 68'(cc_p1) * 68'(vv_p1);
	assign hs = 35'(uu_p2) + 35'(t_p2);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_p1 <= 1'b0;
			v_p2 <= 1'b0;
			v_p3 <= 1'b0;
		end else if (en) begin
			v_p1 <= rv[CordicSteps];
			v_p2 <= v_p1;
			v_p3 <= v_p2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cc_p1 <= 34'(m_cc >>> 30);
			uu_p1 <= 34'(m_uu >>> 30);
			vv_p1 <= 34'(m_vv >>> 30);
			t_p2 <= 34'(m_h >>> 30);
			uu_p2 <= uu_p1;
			if (hs < 35'sd0) begin
				h_p3 <= '0;
			end else if (hs > 35'(Q30One)) begin
				h_p3 <= 34'(Q30One);
			end else begin
				h_p3 <= 34'(hs);
			end
		end
	end

	// Square root chain: 32 cells on h and 1-h.
	logic sv [SqrtSteps+1];
	logic [1:0][63:0] sn_c [SqrtSteps+1];
	logic [1:0][63:0] sr_c [SqrtSteps+1];

	assign sv[0] = v_p3;
	assign sn_c[0][0] = {h_p3[31:0], 30'd0, 2'b00} >> 2;
	assign sn_c[0][1] = {30'd0, 34'(Q30One) - h_p3} << 30;
	assign sr_c[0] = '0;

	for (genvar g = 0; g < SqrtSteps; g++) begin : g_sqrt
		hvd_sqrt_cell u_cell (
			.clk(clk), .arst_n(arst_n), .en(en), .step(5'(g)),
			.in_valid(sv[g]), .n_in(sn_c[g]), .r_in(sr_c[g]),
			.out_valid(sv[g+1]), .n_out(sn_c[g+1]), .r_out(sr_c[g+1])
		);
	end

	// Vectoring chain: atan2(ra, rb).
	logic vv [CordicSteps+1];
	logic signed [34:0] vx [CordicSteps+1];
	logic signed [34:0] vy [CordicSteps+1];
	logic signed [33:0] vz [CordicSteps+1];

	assign vv[0] = sv[SqrtSteps];
	assign vx[0] = signed'({1'b0, sr_c[SqrtSteps][1][33:0]});
	assign vy[0] = signed'({1'b0, sr_c[SqrtSteps][0][33:0]});
	assign vz[0] = '0;

	for (genvar g = 0; g < CordicSteps; g++) begin : g_vec
		hvd_vec_cell u_cell (
			.clk(clk), .arst_n(arst_n), .en(en), .step(5'(g)),
			.in_valid(vv[g]), .x_in(vx[g]), .y_in(vy[g]), .z_in(vz[g]),
			.out_valid(vv[g+1]), .x_out(vx[g+1]), .y_out(vy[g+1]), .z_out(vz[g+1])
		);
	end

	// Scaling: clamp angle, multiply by the distance constant, round.
	logic v_d1, v_d2;
	logic [30:0] zc_d1;
	logic [60:0] dp_d2;
	logic signed [33:0] zf;
	logic [60:0] dsum;

	assign zf = vz[CordicSteps];
	assign dsum = dp_d2 + (61'd1 << 35);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_d1 <= 1'b0;
			v_d2 <= 1'b0;
			out_valid <= 1'b0;
		end else if (en) begin
			v_d1 <= vv[CordicSteps];
			v_d2 <= v_d1;
			out_valid <= v_d2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (zf < 34'sd0) begin
				zc_d1 <= '0;
			end else if (zf > Q30One) begin
				zc_d1 <= 31'(Q30One);
			end else begin
				zc_d1 <= 31'(zf);
			end
			dp_d2 <= 61'(zc_d1) * 61'(DistK);
			distance <= dsum[58:36];
		end
	end

	// The output slot only changes when the pipeline is allowed to move.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(distance))
		else $error("output word changed while stalled");
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		ready == (!out_valid || out_ready))
		else $error("ready does not follow the output slot");
	a_adv: assert property (@(posedge clk) disable iff (!arst_n)
		en && v_d2 |=> out_valid)
		else $error("scaled word lost");
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> distance <= 23'd5125000)
		else $error("distance out of range");
endmodule

### rtl/core/hvd_rot_cell.sv
// One CORDIC rotation cell: four lanes of sine and cosine, one micro-rotation each.
module hvd_rot_cell (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic [4:0] step,
	input  logic in_valid,
	input  logic signed [3:0][33:0] x_in,
	input  logic signed [3:0][33:0] y_in,
	input  logic signed [3:0][31:0] z_in,
	input  logic [3:0][1:0] q_in,
	output logic out_valid,
	output logic signed [3:0][33:0] x_out,
	output logic signed [3:0][33:0] y_out,
	output logic signed [3:0][31:0] z_out,
	output logic [3:0][1:0] q_out
);
	import hvd_pkg::*;

	logic signed [31:0] ang;
	// Lane values as signed words so that the shifts keep the sign.
	logic signed [33:0] xi [4];
	logic signed [33:0] yi [4];
	logic signed [33:0] dx [4];
	logic signed [33:0] dy [4];

	assign ang = signed'({2'b00, atan_turn(step)});

	always_comb begin
		for (int l = 0; l < 4; l++) begin
			xi[l] = x_in[l];
			yi[l] = y_in[l];
			dx[l] = yi[l] >>> step;
			dy[l] = xi[l] >>> step;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int l = 0; l < 4; l++) begin
				if (!z_in[l][31]) begin
					x_out[l] <= xi[l] - dx[l];
					y_out[l] <= yi[l] + dy[l];
					z_out[l] <= z_in[l] - ang;
				end else begin
					x_out[l] <= xi[l] + dx[l];
					y_out[l] <= yi[l] - dy[l];
					z_out[l] <= z_in[l] + ang;
				end
				q_out[l] <= q_in[l];
			end
		end
	end
endmodule

### rtl/core/hvd_sqrt_cell.sv
// One bitwise square root cell: two roots advance by one result bit each.
module hvd_sqrt_cell (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic [4:0] step,
	input  logic in_valid,
	input  logic [1:0][63:0] n_in,
	input  logic [1:0][63:0] r_in,
	output logic out_valid,
	output logic [1:0][63:0] n_out,
	output logic [1:0][63:0] r_out
);
	import hvd_pkg::*;

	logic [63:0] bitv;
	logic [63:0] trial [2];

	assign bitv = 64'd1 << (6'd62 - {step, 1'b0});

	always_comb begin
		for (int l = 0; l < 2; l++) begin
			trial[l] = r_in[l] + bitv;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int l = 0; l < 2; l++) begin
				if (n_in[l] >= trial[l]) begin
					n_out[l] <= n_in[l] - trial[l];
					r_out[l] <= (r_in[l] >> 1) + bitv;
				end else begin
					n_out[l] <= n_in[l];
					r_out[l] <= r_in[l] >> 1;
				end
			end
		end
	end
endmodule

### rtl/core/hvd_vec_cell.sv
// One CORDIC vectoring cell: a single micro-rotation toward the x axis.
module hvd_vec_cell (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic [4:0] step,
	input  logic in_valid,
	input  logic signed [34:0] x_in,
	input  logic signed [34:0] y_in,
	input  logic signed [33:0] z_in,
	output logic out_valid,
	output logic signed [34:0] x_out,
	output logic signed [34:0] y_out,
	output logic signed [33:0] z_out
);
	import hvd_pkg::*;

	logic signed [33:0] ang;

	assign ang = signed'({4'b0000, atan_turn(step)});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			if (y_in > 35'sd0) begin
				x_out <= x_in + (y_in >>> step);
				y_out <= y_in - (x_in >>> step);
				z_out <= z_in + ang;
			end else begin
				x_out <= x_in - (y_in >>> step);
				y_out <= y_in + (x_in >>> step);
				z_out <= z_in - ang;
			end
		end
	end
endmodule
